### hdl/sorted_record_table_top_assert.svh
// Assertion macros for the sorted record table.
`ifndef SORTED_RECORD_TABLE_TOP_ASSERT_SVH
`define SORTED_RECORD_TABLE_TOP_ASSERT_SVH

// Same-cycle implication, held off during reset.
`define SRT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, held off during reset.
`define SRT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/srt_pkg.sv
// Types, constants and name helper for the sorted record table.
package srt_pkg;

	localparam int CAP        = 32;
	localparam int IDX_W      = $clog2(CAP);
	localparam int CNT_W      = $clog2(CAP + 1);
	localparam int COUNT_W    = 6;
	localparam int IN_IDX_W   = 5;
	localparam int CMP_W      = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;
	localparam int NAME_BYTES = 19;
	localparam int NAME_W     = 8 * NAME_BYTES;
	localparam int IN_DATA_W  = 208;
	localparam int OUT_DATA_W = 208;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_REMOVE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;
	localparam logic [1:0] OP_CLEAR  = 2'd3;

	typedef struct packed {
		logic [63:0] name_a;
		logic [63:0] name_b;
		logic [23:0] name_c;
		logic [15:0] volume;
		logic [31:0] price_bits;
	} rec_t;

	// Zero every byte that follows the first zero byte (byte 0 sits in the top bits).
	function automatic logic [NAME_W-1:0] normalize(input logic [NAME_W-1:0] raw);
		logic [NAME_W-1:0] res;
		logic ended;
		for (int i = 0; i < NAME_BYTES; i++) begin
			ended = 1'b0;
			for (int j = 0; j < i; j++) begin
				ended = ended | (raw[NAME_W-1-8*j -: 8] == 8'd0);
			end
			res[NAME_W-1-8*i -: 8] = ended ? 8'd0 : raw[NAME_W-1-8*i -: 8];
		end
		return res;
	endfunction

endpackage

### hdl/sorted_record_table_top.sv
// Sorted record table: key-ordered insert, remove by name, indexed read, clear.
//
// channel  dir  handshake          tdata (low bit up)                         tuser
// s_*      in   s_tvalid/s_tready  name_a, name_b, name_c, volume,           op
//                                  price_bits, index, zero pad to 208
// m_*      out  m_tvalid/m_tready  out_name_a, out_name_b, out_name_c,       ok
//                                  out_volume, out_price_bits, count, pad
//
// Insert walks down over the records it moves, remove walks every stored record, one RAM
// read per cycle, the read data registered; read does a single RAM read, and clear,
// full insert and out-of-range read go straight to the result.
// One request is in work at a time; s_tready is high only while idle.
// A finished result waits for m_tready only while the output register is taken.
// Reset clears count, control and output register; the record RAM has no reset.
`include "sorted_record_table_top_assert.svh"

module sorted_record_table_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// name_a[63:0], name_b[127:64], name_c[151:128], volume[167:152],
	// price_bits[199:168], index[204:200], zero[207:205]
	input  logic [srt_pkg::IN_DATA_W-1:0]     s_tdata,
	// op[1:0]
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_name_a[63:0], out_name_b[127:64], out_name_c[151:128],
	// out_volume[167:152], out_price_bits[199:168], count[205:200], zero[207:206]
	output logic [srt_pkg::OUT_DATA_W-1:0]    m_tdata,
	// ok[0]
	output logic [0:0]                        m_tuser
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INS  = 3'd1;
	localparam logic [2:0] ST_DEL  = 3'd2;
	localparam logic [2:0] ST_RD   = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	localparam logic [srt_pkg::CNT_W-1:0] CAP_CNT = srt_pkg::CNT_W'(srt_pkg::CAP);

	// request fields
	logic [63:0]                   in_name_a;
	logic [63:0]                   in_name_b;
	logic [23:0]                   in_name_c;
	logic [15:0]                   in_volume;
	logic [31:0]                   in_price_bits;
	logic [srt_pkg::IN_IDX_W-1:0]  in_index;
	logic [srt_pkg::NAME_W-1:0]    in_key;

	// control
	logic [2:0]                    state_q;
	logic [srt_pkg::CNT_W-1:0]     count_q;
	logic [srt_pkg::CNT_W-1:0]     left_q;      // reads still to issue
	logic [srt_pkg::IDX_W-1:0]     raddr_q;     // next read address
	logic                          v_s1;        // read data valid this cycle
	logic [srt_pkg::IDX_W-1:0]     addr_s1;     // address of that data
	logic                          found_q;     // remove: match seen, shifting down

	// request payload
	logic [srt_pkg::NAME_W-1:0]    key_q;
	logic [15:0]                   vol_q;
	logic [31:0]                   price_q;

	// pending result and output register
	logic                          res_ok_q;
	srt_pkg::rec_t                 res_rec_q;
	logic                          m_tvalid_q;
	logic                          m_ok_q;
	srt_pkg::rec_t                 m_rec_q;
	logic [srt_pkg::COUNT_W-1:0]   m_count_q;

	// record RAM
	srt_pkg::rec_t                 mem_q [srt_pkg::CAP];
	srt_pkg::rec_t                 rd_data_q;
	logic                          mem_we;
	logic [srt_pkg::IDX_W-1:0]     mem_waddr;
	srt_pkg::rec_t                 mem_wdata;

	srt_pkg::rec_t                 new_rec;
	logic [srt_pkg::NAME_W-1:0]    rd_name;
	logic                          new_lt;
	logic                          name_eq;
	logic                          walk_wr;     // states that write the RAM
	logic                          walking;     // states that read the RAM
	logic                          issue;
	logic                          ins_end;     // insert placed its record
	logic                          out_load;    // result moves to the output register
	logic                          done_stall;
	logic                          accept;

	assign in_name_a     = s_tdata[63:0];
	assign in_name_b     = s_tdata[127:64];
	assign in_name_c     = s_tdata[151:128];
	assign in_volume     = s_tdata[167:152];
	assign in_price_bits = s_tdata[199:168];
	assign in_index      = s_tdata[204:200];
	assign in_key        = srt_pkg::normalize({in_name_a, in_name_b, in_name_c});

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	assign new_rec.name_a     = key_q[srt_pkg::NAME_W-1 -: 64];
	assign new_rec.name_b     = key_q[srt_pkg::NAME_W-65 -: 64];
	assign new_rec.name_c     = key_q[23:0];
	assign new_rec.volume     = vol_q;
	assign new_rec.price_bits = price_q;

	assign rd_name = {rd_data_q.name_a, rd_data_q.name_b, rd_data_q.name_c};
	// new key and volume strictly below the stored ones: that entry moves up
	assign new_lt  = {key_q, vol_q} < {rd_name, rd_data_q.volume};
	assign name_eq = (key_q == rd_name);
	assign walk_wr = (state_q == ST_INS) || (state_q == ST_DEL);
	assign walking = walk_wr || (state_q == ST_RD);
	assign issue   = (left_q != '0) && walking;
	// slot found above an entry whose key and volume are not greater than ours, or bottom reached
	assign ins_end = (state_q == ST_INS) &&
	                 ((v_s1 && !new_lt) || (!v_s1 && left_q == '0));
	assign out_load   = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);
	assign done_stall = (state_q == ST_DONE) && m_tvalid_q && !m_tready;

	// Insert walks down from the top entry, remove walks up from entry 0;
	// writes always land behind the read pointer, so no forwarding is needed.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = srt_pkg::IDX_W'(addr_s1 + 1'b1);
		mem_wdata = rd_data_q;
		case (state_q)
			ST_INS: begin
				if (v_s1) begin
					mem_we    = 1'b1;
					mem_wdata = new_lt ? rd_data_q : new_rec;
				end else if (left_q == '0) begin
					mem_we    = 1'b1;
					mem_waddr = '0;
					mem_wdata = new_rec;
				end
			end
			ST_DEL: begin
				if (v_s1 && found_q) begin
					mem_we    = 1'b1;
					mem_waddr = srt_pkg::IDX_W'(addr_s1 - 1'b1);
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem_q[raddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			left_q     <= '0;
			raddr_q    <= '0;
			v_s1       <= 1'b0;
			addr_s1    <= '0;
			found_q    <= 1'b0;
			key_q      <= '0;
			vol_q      <= '0;
			price_q    <= '0;
			res_ok_q   <= 1'b0;
			res_rec_q  <= '0;
			m_tvalid_q <= 1'b0;
			m_ok_q     <= 1'b0;
			m_rec_q    <= '0;
			m_count_q  <= '0;
		end else begin
			// read issue, shared by the walking states
			if (issue) begin
				left_q  <= ins_end ? '0 : left_q - 1'b1;
				raddr_q <= (state_q == ST_INS) ? srt_pkg::IDX_W'(raddr_q - 1'b1)
				                               : srt_pkg::IDX_W'(raddr_q + 1'b1);
				addr_s1 <= raddr_q;
			end
			v_s1 <= issue && !ins_end;

			// output register: take a finished result, else drop an accepted one
			if (out_load) begin
				m_tvalid_q <= 1'b1;
				m_ok_q     <= res_ok_q;
				m_rec_q    <= res_rec_q;
				m_count_q  <= srt_pkg::COUNT_W'(count_q);
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						key_q     <= in_key;
						vol_q     <= in_volume;
						price_q   <= in_price_bits;
						res_rec_q <= '0;
						res_ok_q  <= (s_tuser == srt_pkg::OP_CLEAR) && (count_q != '0);
						found_q   <= 1'b0;
						case (s_tuser)
							srt_pkg::OP_INSERT: begin
								if (count_q < CAP_CNT) begin
									left_q  <= count_q;
									raddr_q <= srt_pkg::IDX_W'(count_q - 1'b1);
									state_q <= ST_INS;
								end else begin
									state_q <= ST_DONE;
								end
							end
							srt_pkg::OP_REMOVE: begin
								left_q  <= count_q;
								raddr_q <= '0;
								state_q <= ST_DEL;
							end
							srt_pkg::OP_READ: begin
								if (srt_pkg::CMP_W'(in_index) < srt_pkg::CMP_W'(count_q)) begin
									left_q  <= srt_pkg::CNT_W'(1);
									raddr_q <= srt_pkg::IDX_W'(in_index);
									state_q <= ST_RD;
								end else begin
									state_q <= ST_DONE;
								end
							end
							srt_pkg::OP_CLEAR: begin
								count_q  <= '0;
								state_q  <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_INS: begin
					if (ins_end) begin
						count_q  <= count_q + 1'b1;
						res_ok_q <= 1'b1;
						state_q  <= ST_DONE;
					end
				end
				ST_DEL: begin
					if (v_s1 && !found_q && name_eq) begin
						found_q <= 1'b1;
					end
					if (!v_s1 && left_q == '0) begin
						res_ok_q <= found_q;
						count_q  <= count_q - srt_pkg::CNT_W'(found_q);
						state_q  <= ST_DONE;
					end
				end
				ST_RD: begin
					if (v_s1) begin
						res_rec_q <= rd_data_q;
						res_ok_q  <= 1'b1;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tuser  = m_ok_q;
	assign m_tdata  = {2'b00, m_count_q, m_rec_q.price_bits, m_rec_q.volume,
	                   m_rec_q.name_c, m_rec_q.name_b, m_rec_q.name_a};

	`SRT_ASSERT_IMP(a_count_max, 1'b1, count_q <= CAP_CNT, "count above capacity")
	`SRT_ASSERT_IMP(a_wr_state, mem_we, walk_wr, "RAM write outside a walk")
	`SRT_ASSERT_IMP(a_wr_range, mem_we, {1'b0, mem_waddr} <= count_q, "RAM write past table end")
	`SRT_ASSERT_NXT(a_accept_busy, accept, state_q != ST_IDLE, "accepted but still idle")
	`SRT_ASSERT_NXT(a_done_hold, done_stall, state_q == ST_DONE, "result dropped in stall")
	`SRT_ASSERT_IMP(a_rd_valid, v_s1, walking, "read data flagged outside a walk")

endmodule
